// File: src/tlag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlag_pkg
// Shared types, register indexes and helpers for the tile layer address
// generator.
// ----------------------------------------------------------------------------
package tlag_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MAP_BASE      = 3'd0,
    REG_SCREEN_LAYOUT = 3'd1,
    REG_LARGE_TILES   = 3'd2,
    REG_HIGH_RES      = 3'd3,
    REG_PLANE_DEPTH   = 3'd4,
    REG_CHAR_BASE     = 3'd5,
    REG_PALETTE_BASE  = 3'd6
  } tlag_reg_t;

  typedef enum logic {
    CMD_MAP  = 1'b0,
    CMD_CHAR = 1'b1
  } tlag_cmd_t;

  localparam logic [11:0] ScreenStep = 12'h400;

  typedef struct packed {
    logic        command;
    logic [11:0] h_position;
    logic [11:0] v_position;
    logic [15:0] map_entry;
  } tlag_in_t;

  typedef struct packed {
    logic [15:0] address;
    logic [10:0] pal_index;
    logic        high_priority;
    logic        flip_x;
  } tlag_out_t;

  typedef struct packed {
    logic [15:0] map_base;
    logic [1:0]  screen_layout;
    logic        large_tiles;
    logic        high_res;
    logic [1:0]  plane_depth;
    logic [15:0] char_base;
    logic [6:0]  palette_base;
  } tlag_cfg_t;

  // first stage result
  typedef struct packed {
    logic       command;
    logic [7:0] tile_x;
    logic [7:0] tile_y;
    logic [9:0] tile;
    logic [2:0] row;
    logic [2:0] pal;
    logic       prio;
    logic       flip_x;
  } tlag_s1_t;

  // second stage result
  typedef struct packed {
    logic        command;
    logic [11:0] map_off;
    logic [11:0] chr;
    logic [2:0]  row;
    logic [10:0] pal_index;
    logic        prio;
    logic        flip_x;
  } tlag_s2_t;

  // depth code three behaves as eight bitplanes
  function automatic logic [1:0] eff_depth(input logic [1:0] code);
    eff_depth = (code == 2'd3) ? 2'd2 : code;
  endfunction

endpackage

// File: src/tile_layer_address_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_layer_address_generator_top
// Map entry and character row address generation for one tiled layer.
//
// channel  ports                          transfer
// input    start, busy, in_data           start high while busy low
// result   out_strobe, out_data           out_strobe high, one cycle only
// config   cfg_valid, cfg_ready,          cfg_valid and cfg_ready high
//          cfg_index, cfg_data
//
// one command per cycle, each result passing three register stages:
// masking, offsets, final sums
// busy and cfg_ready are constant, nothing ever holds the pipeline
// synchronous active-low reset clears the config registers and pipeline valids
// ----------------------------------------------------------------------------
module tile_layer_address_generator_top
  import tlag_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tlag_in_t             in_data,
  output logic                 out_strobe,
  output tlag_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  tlag_cfg_t cfg;
  logic      s1_valid;
  tlag_s1_t  s1_item;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  tlag_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlag_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (start & ~busy),
    .in_item  (in_data),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tlag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_valid (out_strobe),
    .out_item  (out_data)
  );

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    |-> (out_strobe == $past(start, 3)))
    else $error("result strobe does not follow start by three cycles");

  a_map_side : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(start, 3)
     && ($past(in_data.command, 3) == CMD_MAP))
    |-> (out_data.pal_index == '0 && !out_data.high_priority && !out_data.flip_x))
    else $error("map result carries non-zero side fields");

  a_char_flags : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(start, 3)
     && ($past(in_data.command, 3) == CMD_CHAR))
    |-> (out_data.flip_x == $past(in_data.map_entry[14], 3)
         && out_data.high_priority == $past(in_data.map_entry[13], 3)))
    else $error("character result flags do not match map entry");
`endif

endmodule

// File: src/tlag_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlag_cfg
// Configuration register file, one write transfer per cycle.
// ----------------------------------------------------------------------------
module tlag_cfg
  import tlag_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  output tlag_cfg_t            cfg
);

  tlag_cfg_t cfg_r;
  tlag_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (tlag_reg_t'(wr_index))
        REG_MAP_BASE:      cfg_nxt.map_base      = wr_data;
        REG_SCREEN_LAYOUT: cfg_nxt.screen_layout = wr_data[1:0];
        REG_LARGE_TILES:   cfg_nxt.large_tiles   = wr_data[0];
        REG_HIGH_RES:      cfg_nxt.high_res      = wr_data[0];
        REG_PLANE_DEPTH:   cfg_nxt.plane_depth   = wr_data[1:0];
        REG_CHAR_BASE:     cfg_nxt.char_base     = wr_data;
        REG_PALETTE_BASE:  cfg_nxt.palette_base  = wr_data[6:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/tlag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlag_front
// First pipeline stage: playfield masking, tile coordinates, neighbour tile
// selection and flipped row.
// ----------------------------------------------------------------------------
module tlag_front
  import tlag_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tlag_cfg_t cfg,
  input  logic      in_valid,
  input  tlag_in_t  in_item,
  output logic      s1_valid,
  output tlag_s1_t  s1_item
);

  logic        tw4;
  logic        th4;
  logic [3:0]  h_bits;
  logic [3:0]  v_bits;
  logic [11:0] h_pos;
  logic [11:0] v_pos;
  logic [11:0] tx_full;
  logic [11:0] ty_full;
  logic        fy;
  logic        fx;
  logic        adj_x;
  logic        adj_y;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  tlag_s1_t s1_item_r;
  tlag_s1_t s1_item_nxt;

  always_comb begin
    th4     = cfg.large_tiles;
    tw4     = cfg.large_tiles | cfg.high_res;
    h_bits  = 4'd8 + {3'b0, cfg.high_res} + {3'b0, cfg.large_tiles}
              + {3'b0, cfg.screen_layout[0]};
    v_bits  = 4'd8 + {3'b0, cfg.high_res} + {3'b0, cfg.large_tiles}
              + {3'b0, cfg.screen_layout[1]};
    h_pos   = in_item.h_position & ~(12'hfff << h_bits);
    v_pos   = in_item.v_position & ~(12'hfff << v_bits);
    tx_full = tw4 ? (h_pos >> 4) : (h_pos >> 3);
    ty_full = th4 ? (v_pos >> 4) : (v_pos >> 3);
    fy      = in_item.map_entry[15];
    fx      = in_item.map_entry[14];
    adj_x   = tw4 && (h_pos[3] != fx);
    adj_y   = th4 && (v_pos[3] != fy);

    s1_valid_nxt        = in_valid;
    s1_item_nxt.command = in_item.command;
    s1_item_nxt.tile_x  = tx_full[7:0];
    s1_item_nxt.tile_y  = ty_full[7:0];
    s1_item_nxt.tile    = in_item.map_entry[9:0] + {9'b0, adj_x} + {5'b0, adj_y, 4'b0};
    s1_item_nxt.row     = v_pos[2:0] ^ {3{fy}};
    s1_item_nxt.pal     = in_item.map_entry[12:10];
    s1_item_nxt.prio    = in_item.map_entry[13];
    s1_item_nxt.flip_x  = fx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// File: src/tlag_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlag_back
// Second and third pipeline stages: map offset, character number and
// palette index, then the final address sums and the result register.
// ----------------------------------------------------------------------------
module tlag_back
  import tlag_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tlag_cfg_t cfg,
  input  logic      s1_valid,
  input  tlag_s1_t  s1_item,
  output logic      out_valid,
  output tlag_out_t out_item
);

  logic [1:0]  depth;
  logic [11:0] sx;
  logic [11:0] sy;
  logic [11:0] cbase;
  logic [11:0] chr_mask;
  logic [3:0]  pal_shift;
  logic [4:0]  chr_shift;

  logic      s2_valid_r;
  logic      s2_valid_nxt;
  tlag_s2_t  s2_item_r;
  tlag_s2_t  s2_item_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  tlag_out_t out_item_r;
  tlag_out_t out_item_nxt;

  // stage two
  always_comb begin
    depth     = eff_depth(cfg.plane_depth);
    sx        = cfg.screen_layout[0] ? ScreenStep : 12'h000;
    sy        = cfg.screen_layout[1]
                ? (cfg.screen_layout[0] ? (ScreenStep << 1) : ScreenStep) : 12'h000;
    cbase     = cfg.char_base[15:4] >> depth;
    chr_mask  = 12'hfff >> depth;
    pal_shift = 4'd2 << depth;

    s2_valid_nxt          = s1_valid;
    s2_item_nxt.command   = s1_item.command;
    s2_item_nxt.map_off   = {2'b0, s1_item.tile_y[4:0], s1_item.tile_x[4:0]}
                            + (s1_item.tile_x[5] ? sx : 12'h000)
                            + (s1_item.tile_y[5] ? sy : 12'h000);
    s2_item_nxt.chr       = ({2'b0, s1_item.tile} + cbase) & chr_mask;
    s2_item_nxt.row       = s1_item.row;
    s2_item_nxt.prio      = s1_item.prio;
    s2_item_nxt.flip_x    = s1_item.flip_x;
    if (tlag_cmd_t'(s1_item.command) == CMD_CHAR) begin
      s2_item_nxt.pal_index = ({8'b0, s1_item.pal} << pal_shift)
                              + {4'b0, cfg.palette_base};
    end else begin
      s2_item_nxt.pal_index = '0;
    end
  end

  // stage three
  always_comb begin
    chr_shift     = 5'd4 + {3'b0, depth};
    out_valid_nxt = out_valid_r;
    out_valid_nxt = s2_valid_r;
    if (tlag_cmd_t'(s2_item_r.command) == CMD_CHAR) begin
      out_item_nxt.address       = ({4'b0, s2_item_r.chr} << chr_shift)
                                   + {12'b0, s2_item_r.row, 1'b0};
      out_item_nxt.pal_index     = s2_item_r.pal_index;
      out_item_nxt.high_priority = s2_item_r.prio;
      out_item_nxt.flip_x        = s2_item_r.flip_x;
    end else begin
      out_item_nxt.address       = cfg.map_base + {3'b0, s2_item_r.map_off, 1'b0};
      out_item_nxt.pal_index     = '0;
      out_item_nxt.high_priority = 1'b0;
      out_item_nxt.flip_x        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r  <= s2_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/tile_layer_address_generator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_layer_address_generator_top_test
// Checks map entry and character row fetch addresses for one tiled layer.
// A short table of probes runs after reset, its first rows with fixed expected
// values, and again with every register at its top value. Register settings
// follow, fixed and random, each with a run of map and character fetch pairs
// and loose commands. Other results are compared with a local model of the
// layer address logic. Gaps on the command side come in random bursts.
// ----------------------------------------------------------------------------
module tile_layer_address_generator_top_test;
  import tlag_pkg::*;

  localparam logic [CfgIndexW-1:0] RegIndexUnused = 3'd7;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 53;
  localparam int StallLimit = 2000;
  localparam int MaxReports = 10;
  localparam int ProbeCount = 11;

  localparam tlag_cfg_t RegsAllHigh = '{
    map_base: 16'hffff, screen_layout: 2'd3, large_tiles: 1'b1, high_res: 1'b1,
    plane_depth: 2'd3, char_base: 16'hffff, palette_base: 7'd127
  };

  typedef struct {
    tlag_in_t  item;
    logic      pinned;
    tlag_out_t result;
  } probe_row_t;

  typedef struct {
    tlag_cmd_t cmd;
    tlag_out_t result;
  } fetch_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  tlag_in_t             in_data;
  logic                 out_strobe;
  tlag_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  logic      pin_valid;
  tlag_out_t pin_result;

  tlag_cfg_t layer_regs;
  fetch_t    pending_fetches[$];
  int        mismatches;
  int        map_checked;
  int        char_checked;
  int        settings_used;
  int        stall_cycles;

  probe_row_t probe_table [ProbeCount] = '{
    '{'{CMD_MAP,  12'h000, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_MAP,  12'hfff, 12'hfff, 16'h0000}, 1'b1, '{16'h07fe, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_MAP,  12'h000, 12'h000, 16'hffff}, 1'b1, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_CHAR, 12'h000, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_CHAR, 12'h000, 12'h000, 16'hffff}, 1'b1, '{16'h3ffe, 11'd28, 1'b1, 1'b1}},
    '{'{CMD_CHAR, 12'h008, 12'h008, 16'h4000}, 1'b0, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_CHAR, 12'h123, 12'h456, 16'h8000}, 1'b0, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_CHAR, 12'hfff, 12'hfff, 16'h2c00}, 1'b0, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_MAP,  12'h0a5, 12'h15a, 16'h0000}, 1'b0, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_CHAR, 12'h0f8, 12'h00f, 16'h03ff}, 1'b0, '{16'h0000, 11'd0,  1'b0, 1'b0}},
    '{'{CMD_MAP,  12'h800, 12'h800, 16'h5a5a}, 1'b0, '{16'h0000, 11'd0,  1'b0, 1'b0}}
  };

  tile_layer_address_generator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tlag_out_t predict_fetch(tlag_in_t item, tlag_cfg_t regs);
    int unsigned depth, hpos, vpos, span_x, span_y, tile_x, tile_y;
    int unsigned offset, tile, chr, row, pal;
    logic        wide, tall;
    tlag_out_t   res;
    res = '0;
    depth = (regs.plane_depth == 2'd3) ? 2 : regs.plane_depth;
    tall = regs.large_tiles;
    wide = regs.large_tiles | regs.high_res;
    span_x = regs.high_res ? 512 : 256;
    if (tall) span_x = span_x << 1;
    span_y = span_x;
    if (regs.screen_layout[0]) span_x = span_x << 1;
    if (regs.screen_layout[1]) span_y = span_y << 1;
    hpos = item.h_position & (span_x - 1);
    vpos = item.v_position & (span_y - 1);
    if (item.command == CMD_MAP) begin
      tile_x = hpos >> (wide ? 4 : 3);
      tile_y = vpos >> (tall ? 4 : 3);
      offset = ((tile_y & 'h1f) << 5) + (tile_x & 'h1f);
      if (tile_x[5] && regs.screen_layout[0]) offset += ScreenStep;
      if (tile_y[5] && regs.screen_layout[1]) begin
        offset += (regs.screen_layout == 2'd3) ? 2 * ScreenStep : ScreenStep;
      end
      res.address = 16'(regs.map_base + (offset << 1));
    end else begin
      tile = item.map_entry;
      if (wide && (hpos[3] != item.map_entry[14])) tile += 1;
      if (tall && (vpos[3] != item.map_entry[15])) tile += 16;
      chr = ((tile & 'h3ff) + (regs.char_base >> (4 + depth))) & ('hfff >> depth);
      row = vpos & 7;
      if (item.map_entry[15]) row = row ^ 7;
      pal = item.map_entry[12:10];
      res.address = 16'((chr << (4 + depth)) + (row << 1));
      res.pal_index = 11'(regs.palette_base + (pal << (2 << depth)));
      res.high_priority = item.map_entry[13];
      res.flip_x = item.map_entry[14];
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_address();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic tlag_cfg_t pick_regs();
    tlag_cfg_t c;
    c.map_base = pick_address();
    c.screen_layout = 2'($urandom_range(0, 3));
    c.large_tiles = 1'($urandom_range(0, 1));
    c.high_res = 1'($urandom_range(0, 1));
    c.plane_depth = 2'($urandom_range(0, 3));
    c.char_base = pick_address();
    c.palette_base = ($urandom_range(0, 3) == 0) ? 7'd96 : 7'($urandom_range(0, 127));
    return c;
  endfunction

  task automatic report_fault(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%s", msg);
  endtask

  // result check, expectation capture, register shadow and stall watchdog
  always @(posedge clk) begin
    fetch_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_fetches.size() == 0) begin
          report_fault($sformatf("unexpected result at %0t: addr %h", $realtime,
                                 out_data.address));
        end else begin
          want = pending_fetches.pop_front();
          if (want.cmd == CMD_MAP) map_checked++;
          else char_checked++;
          if (out_data.address !== want.result.address ||
              out_data.pal_index !== want.result.pal_index ||
              out_data.high_priority !== want.result.high_priority ||
              out_data.flip_x !== want.result.flip_x) begin
            report_fault({
              $sformatf("%s fetch mismatch at %0t: expected addr %h pal %h prio %b flip %b,",
                        want.cmd.name(), $realtime, want.result.address,
                        want.result.pal_index, want.result.high_priority,
                        want.result.flip_x),
              $sformatf(" got addr %h pal %h prio %b flip %b",
                        out_data.address, out_data.pal_index, out_data.high_priority,
                        out_data.flip_x)});
          end
        end
      end
      if (start && !busy) begin
        want.cmd = tlag_cmd_t'(in_data.command);
        want.result = pin_valid ? pin_result : predict_fetch(in_data, layer_regs);
        pending_fetches.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_BASE:      layer_regs.map_base = cfg_data;
          REG_SCREEN_LAYOUT: layer_regs.screen_layout = cfg_data[1:0];
          REG_LARGE_TILES:   layer_regs.large_tiles = cfg_data[0];
          REG_HIGH_RES:      layer_regs.high_res = cfg_data[0];
          REG_PLANE_DEPTH:   layer_regs.plane_depth = cfg_data[1:0];
          REG_CHAR_BASE:     layer_regs.char_base = cfg_data;
          REG_PALETTE_BASE:  layer_regs.palette_base = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("no transfer for %0d cycles at %0t", StallLimit, $realtime);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic send_fetch(input tlag_in_t item, input logic pinned,
                            input tlag_out_t result);
    @(negedge clk);
    start <= 1'b1;
    in_data <= item;
    pin_valid <= pinned;
    pin_result <= result;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_input(input int cycles);
    logic [63:0] junk;
    repeat (cycles) begin
      junk = {$urandom, $urandom};
      @(negedge clk);
      start <= 1'b0;
      in_data <= junk[$bits(tlag_in_t)-1:0];
      pin_valid <= 1'b0;
    end
  endtask

  task automatic maybe_idle(input logic quiet);
    if (!quiet && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 7));
  endtask

  task automatic wait_drained();
    while (pending_fetches.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic program_regs(input tlag_cfg_t c);
    write_reg(REG_MAP_BASE, c.map_base);
    write_reg(REG_SCREEN_LAYOUT, {14'($urandom), c.screen_layout});
    write_reg(REG_LARGE_TILES, {15'($urandom), c.large_tiles});
    write_reg(REG_HIGH_RES, {15'($urandom), c.high_res});
    write_reg(REG_PLANE_DEPTH, {14'($urandom), c.plane_depth});
    write_reg(REG_CHAR_BASE, c.char_base);
    write_reg(REG_PALETTE_BASE, {9'($urandom), c.palette_base});
    write_reg(RegIndexUnused, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_probes(input logic with_pins);
    for (int i = 0; i < ProbeCount; i++) begin
      send_fetch(probe_table[i].item, with_pins && probe_table[i].pinned,
                 probe_table[i].result);
    end
    idle_input(1);
  endtask

  initial begin
    tlag_in_t    item;
    tlag_cfg_t   regs;
    logic [11:0] h;
    logic [11:0] v;
    logic        quiet;
    int          sent;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    pin_valid = 1'b0;
    pin_result = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    layer_regs = '0;
    mismatches = 0;
    map_checked = 0;
    char_checked = 0;
    settings_used = 1;
    stall_cycles = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    run_probes(1'b1);
    wait_drained();
    program_regs(RegsAllHigh);
    run_probes(1'b0);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      quiet = (phase == PhaseCount - 1) || ($urandom_range(0, 3) == 0);
      if (phase == 0) regs = '0;
      else if (phase == 1) regs = RegsAllHigh;
      else regs = pick_regs();
      wait_drained();
      program_regs(regs);
      sent = 0;
      while (sent < PhaseItems) begin
        h = 12'($urandom);
        v = 12'($urandom);
        item.h_position = h;
        item.v_position = v;
        item.map_entry = 16'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          // map fetch then character fetch for the same spot
          item.command = CMD_MAP;
          maybe_idle(quiet);
          send_fetch(item, 1'b0, '0);
          item.map_entry = 16'($urandom);
          item.command = CMD_CHAR;
          maybe_idle(quiet);
          send_fetch(item, 1'b0, '0);
          sent += 2;
        end else begin
          item.command = $urandom_range(0, 1) ? CMD_CHAR : CMD_MAP;
          maybe_idle(quiet);
          send_fetch(item, 1'b0, '0);
          sent++;
        end
      end
      idle_input(1);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d map and %0d character fetches checked under %0d register settings,",
             map_checked, char_checked, settings_used);
    $display("including depth code three, wrapped sums and writes to an unused index");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tlag_pkg.sv
src/tlag_cfg.sv
src/tlag_front.sv
src/tlag_back.sv
src/tile_layer_address_generator_top.sv
tb/tile_layer_address_generator_top_test.sv
